// ===== rtl/pmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmfd_pkg
// Shared types and constants of the power meter frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmfd_pkg;

    localparam int FRAME_LEN  = 24;
    localparam int POS_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int GAIN_W     = 32;
    localparam int FIELD_W    = 24;
    localparam int PROD_W     = GAIN_W + FIELD_W;
    localparam int RES_W      = 32;
    localparam int PULSE_W    = 16;
    localparam int ENERGY_W   = 48;
    localparam int DIV_STEPS  = PROD_W;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [BYTE_W-1:0] HEADER_OK      = 8'h5A;
    localparam logic [BYTE_W-1:0] POWER_BAD_MASK = 8'hF2;
    localparam logic [BYTE_W-1:0] ADJ_VOLTAGE    = 8'h40;
    localparam logic [BYTE_W-1:0] ADJ_POWER      = 8'h10;
    localparam logic [BYTE_W-1:0] ADJ_CURRENT    = 8'h20;
    localparam logic [GAIN_W-1:0] GAIN_RESET     = 32'h0001_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_GAIN   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_HDR = 2'd1,
        ST_BAD_SUM = 2'd2
    } t_status;

    // Quotient being worked on; OP_NRG closes the frame with the energy update.
    typedef enum logic [1:0] {
        OP_VOLT = 2'd0,
        OP_PWR  = 2'd1,
        OP_CUR  = 2'd2,
        OP_NRG  = 2'd3
    } t_op;

    typedef struct packed {
        logic             byte_we;
        logic             byte_start;
        logic [POS_W-1:0] pos;
        logic             clr_res;
        logic             load_div;
        logic             div_step;
        logic             store_q;
        logic             nrg_upd;
        logic             out_load;
        t_op              op;
    } t_cmd;

    typedef struct packed {
        logic hdr_bad;
        logic sum_bad;
        logic en_volt;
        logic en_pwr;
        logic en_cur;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/pmfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmfd_ctrl
// Sequencer: byte position, frame-end checks, quotient order, divider
// step count and output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmfd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic           i_frame_start,
    output logic                o_valid,
    input  wire logic           i_stall,
    input  wire pmfd_pkg::t_sts i_sts,
    output pmfd_pkg::t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_RECV   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_PICK   = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_STORE  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [pmfd_pkg::POS_W-1:0]      r_pos, n_pos;
    pmfd_pkg::t_op                   r_op, n_op;
    logic [pmfd_pkg::DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic                            r_out_valid, n_out_valid;
    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_op_en;
    pmfd_pkg::t_op                   w_op_next;

    assign o_stall    = (r_state != S_RECV);
    assign o_valid    = r_out_valid;
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        case (r_op)
            pmfd_pkg::OP_VOLT: w_op_en = i_sts.en_volt;
            pmfd_pkg::OP_PWR:  w_op_en = i_sts.en_pwr;
            pmfd_pkg::OP_CUR:  w_op_en = i_sts.en_cur;
            default:           w_op_en = 1'b0;
        endcase
        case (r_op)
            pmfd_pkg::OP_VOLT: w_op_next = pmfd_pkg::OP_PWR;
            pmfd_pkg::OP_PWR:  w_op_next = pmfd_pkg::OP_CUR;
            default:           w_op_next = pmfd_pkg::OP_NRG;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_op        = r_op;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.op    = r_op;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_RECV: begin
                if (w_accept) begin
                    if (i_frame_start) begin
                        o_cmd.byte_we    = 1'b1;
                        o_cmd.byte_start = 1'b1;
                        o_cmd.pos        = '0;
                        n_pos            = pmfd_pkg::POS_W'(1);
                    end else if (r_pos < pmfd_pkg::POS_W'(pmfd_pkg::FRAME_LEN)) begin
                        o_cmd.byte_we = 1'b1;
                        o_cmd.pos     = r_pos;
                        n_pos         = r_pos + pmfd_pkg::POS_W'(1);
                        if (r_pos == pmfd_pkg::POS_W'(pmfd_pkg::FRAME_LEN - 1)) begin
                            n_state = S_CHECK;
                        end
                    end
                    // drop a byte that arrives outside a frame
                end
            end
            S_CHECK: begin
                o_cmd.clr_res = 1'b1;
                n_op          = pmfd_pkg::OP_VOLT;
                if (i_sts.hdr_bad || i_sts.sum_bad) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (r_op == pmfd_pkg::OP_NRG) begin
                    o_cmd.nrg_upd = 1'b1;
                    n_state       = S_OUT;
                end else if (w_op_en) begin
                    n_state = S_MUL;
                end else begin
                    n_op = w_op_next;
                end
            end
            S_MUL: begin
                o_cmd.load_div = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + pmfd_pkg::DIV_CNT_W'(1);
                if (r_cnt == pmfd_pkg::DIV_CNT_W'(pmfd_pkg::DIV_STEPS - 1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store_q = 1'b1;
                n_op          = w_op_next;
                n_state       = S_PICK;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_RECV;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RECV;
            r_pos       <= pmfd_pkg::POS_W'(pmfd_pkg::FRAME_LEN);
            r_op        <= pmfd_pkg::OP_VOLT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_op        <= n_op;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pmfd_dp.sv =====
// ----------------------------------------------------------------------------
// pmfd_dp
// Datapath: frame bytes, running checksum, gain registers, shared
// multiply and restoring divider, energy accumulator and result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmfd_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [pmfd_pkg::BYTE_W-1:0]         i_rx_byte,
    input  wire logic                                i_cfg_valid,
    input  wire logic [pmfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pmfd_pkg::GAIN_W-1:0]         i_cfg_data,
    input  wire pmfd_pkg::t_cmd                      i_cmd,
    output pmfd_pkg::t_sts                           o_sts,
    output logic [1:0]                               o_status,
    output logic [pmfd_pkg::RES_W-1:0]               o_voltage,
    output logic [pmfd_pkg::RES_W-1:0]               o_current,
    output logic [pmfd_pkg::RES_W-1:0]               o_power,
    output logic [pmfd_pkg::ENERGY_W-1:0]            o_energy_micro
);

    logic [pmfd_pkg::BYTE_W-1:0]   r_frame [pmfd_pkg::FRAME_LEN];
    logic [pmfd_pkg::BYTE_W-1:0]   r_sum;
    logic [pmfd_pkg::GAIN_W-1:0]   r_vgain, r_igain, r_pgain;
    logic [pmfd_pkg::RES_W-1:0]    r_volt, r_cur, r_pwr;
    logic [pmfd_pkg::PROD_W-1:0]   r_quo;
    logic [pmfd_pkg::FIELD_W-1:0]  r_rem;
    logic [pmfd_pkg::FIELD_W-1:0]  r_divisor;
    logic [pmfd_pkg::PULSE_W-1:0]  r_last;
    logic [pmfd_pkg::ENERGY_W-1:0] r_energy;
    logic [1:0]                    r_status;
    logic [pmfd_pkg::RES_W-1:0]    r_out_volt, r_out_cur, r_out_pwr;
    logic [pmfd_pkg::ENERGY_W-1:0] r_out_energy;

    logic [pmfd_pkg::FIELD_W-1:0]  w_coef_v, w_cyc_v, w_coef_i, w_cyc_i, w_coef_p, w_cyc_p;
    logic [pmfd_pkg::BYTE_W-1:0]   w_adj;
    logic [pmfd_pkg::GAIN_W-1:0]   w_gain;
    logic [pmfd_pkg::FIELD_W-1:0]  w_coef, w_cyc;
    logic                          w_sum_en;
    logic [pmfd_pkg::FIELD_W:0]    w_rem_sh, w_diff;
    logic [pmfd_pkg::RES_W-1:0]    w_q_sat;
    logic [pmfd_pkg::PULSE_W-1:0]  w_pulses, w_base, w_delta;
    logic [pmfd_pkg::PULSE_W+pmfd_pkg::FIELD_W-1:0] w_add;
    logic [pmfd_pkg::ENERGY_W:0]   w_nrg_sum;

    assign w_coef_v = {r_frame[2],  r_frame[3],  r_frame[4]};
    assign w_cyc_v  = {r_frame[5],  r_frame[6],  r_frame[7]};
    assign w_coef_i = {r_frame[8],  r_frame[9],  r_frame[10]};
    assign w_cyc_i  = {r_frame[11], r_frame[12], r_frame[13]};
    assign w_coef_p = {r_frame[14], r_frame[15], r_frame[16]};
    assign w_cyc_p  = {r_frame[17], r_frame[18], r_frame[19]};
    assign w_adj    = r_frame[20];
    assign w_pulses = {r_frame[21], r_frame[22]};

    assign o_sts.hdr_bad = (r_frame[1] != pmfd_pkg::HEADER_OK);
    assign o_sts.sum_bad = (r_sum != r_frame[23]);
    assign o_sts.en_volt = |(w_adj & pmfd_pkg::ADJ_VOLTAGE);
    assign o_sts.en_pwr  = |(w_adj & pmfd_pkg::ADJ_POWER)
                           && ((r_frame[0] & pmfd_pkg::POWER_BAD_MASK)
                               != pmfd_pkg::POWER_BAD_MASK);
    assign o_sts.en_cur  = |(w_adj & pmfd_pkg::ADJ_CURRENT) && (r_pwr != '0);

    always_comb begin
        case (i_cmd.op)
            pmfd_pkg::OP_VOLT: begin
                w_gain = r_vgain;
                w_coef = w_coef_v;
                w_cyc  = w_cyc_v;
            end
            pmfd_pkg::OP_PWR: begin
                w_gain = r_pgain;
                w_coef = w_coef_p;
                w_cyc  = w_cyc_p;
            end
            default: begin
                w_gain = r_igain;
                w_coef = w_coef_i;
                w_cyc  = w_cyc_i;
            end
        endcase
    end

    always_comb begin
        w_sum_en = i_cmd.pos inside {[5'd2:5'd22]};
    end

    // One restoring step; a zero divisor yields all ones, which saturates.
    assign w_rem_sh = {r_rem, r_quo[pmfd_pkg::PROD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_divisor};
    assign w_q_sat  = (|r_quo[pmfd_pkg::PROD_W-1:pmfd_pkg::RES_W]) ? '1
                      : r_quo[pmfd_pkg::RES_W-1:0];

    assign w_base    = (r_last == '0) ? w_pulses : r_last;
    assign w_delta   = w_pulses - w_base;
    assign w_add     = w_delta * w_coef_p;
    assign w_nrg_sum = {1'b0, r_energy} + (pmfd_pkg::ENERGY_W + 1)'(w_add);

    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_we) begin
            r_frame[i_cmd.pos] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_vgain  <= pmfd_pkg::GAIN_RESET;
            r_igain  <= pmfd_pkg::GAIN_RESET;
            r_pgain  <= pmfd_pkg::GAIN_RESET;
            r_last   <= '0;
            r_energy <= '0;
        end else begin
            if (i_cmd.byte_we) begin
                if (i_cmd.byte_start) begin
                    r_sum <= '0;
                end else if (w_sum_en) begin
                    r_sum <= r_sum + i_rx_byte;
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pmfd_pkg::CFG_VOLTAGE_GAIN: r_vgain <= i_cfg_data;
                    pmfd_pkg::CFG_CURRENT_GAIN: r_igain <= i_cfg_data;
                    pmfd_pkg::CFG_POWER_GAIN:   r_pgain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.nrg_upd) begin
                r_last   <= w_pulses;
                r_energy <= w_nrg_sum[pmfd_pkg::ENERGY_W] ? '1
                            : w_nrg_sum[pmfd_pkg::ENERGY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_quo     <= w_gain * w_coef;
            r_rem     <= '0;
            r_divisor <= w_cyc;
        end else if (i_cmd.div_step) begin
            if (!w_diff[pmfd_pkg::FIELD_W]) begin
                r_rem <= w_diff[pmfd_pkg::FIELD_W-1:0];
                r_quo <= {r_quo[pmfd_pkg::PROD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[pmfd_pkg::FIELD_W-1:0];
                r_quo <= {r_quo[pmfd_pkg::PROD_W-2:0], 1'b0};
            end
        end

        if (i_cmd.clr_res) begin
            r_volt <= '0;
            r_cur  <= '0;
            r_pwr  <= '0;
        end else if (i_cmd.store_q) begin
            case (i_cmd.op)
                pmfd_pkg::OP_VOLT: r_volt <= w_q_sat;
                pmfd_pkg::OP_PWR:  r_pwr  <= w_q_sat;
                pmfd_pkg::OP_CUR:  r_cur  <= w_q_sat;
                default: ;
            endcase
        end

        if (i_cmd.out_load) begin
            if (o_sts.hdr_bad) begin
                r_status <= pmfd_pkg::ST_BAD_HDR;
            end else if (o_sts.sum_bad) begin
                r_status <= pmfd_pkg::ST_BAD_SUM;
            end else begin
                r_status <= pmfd_pkg::ST_OK;
            end
            r_out_volt   <= r_volt;
            r_out_cur    <= r_cur;
            r_out_pwr    <= r_pwr;
            r_out_energy <= r_energy;
        end
    end

    assign o_status       = r_status;
    assign o_voltage      = r_out_volt;
    assign o_current      = r_out_cur;
    assign o_power        = r_out_pwr;
    assign o_energy_micro = r_out_energy;

endmodule

`default_nettype wire

// ===== rtl/power_meter_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// power_meter_frame_decoder
// Decodes 24-byte energy-meter frames into status, voltage, current,
// power and accumulated energy.
// ----------------------------------------------------------------------------
// Each frame byte is taken in one cycle. After the last byte the input
// stalls through the check step, a pass of each reported quotient through the
// one shared 56-step restoring divider, and the energy and output steps.
// The result word waits in an output register while the next frame arrives.
// Synchronous active-low reset: gains to 1.0, energy and pulse state to zero,
// no frame open, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module power_meter_frame_decoder (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [pmfd_pkg::BYTE_W-1:0]      i_rx_byte,
    input  wire logic                             i_frame_start,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [1:0]                            o_status,
    output logic [pmfd_pkg::RES_W-1:0]            o_voltage,
    output logic [pmfd_pkg::RES_W-1:0]            o_current,
    output logic [pmfd_pkg::RES_W-1:0]            o_power,
    output logic [pmfd_pkg::ENERGY_W-1:0]         o_energy_micro,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pmfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pmfd_pkg::GAIN_W-1:0]      i_cfg_data
);

    pmfd_pkg::t_cmd w_cmd;
    pmfd_pkg::t_sts w_sts;

    // gain registers take a word in any cycle
    assign o_cfg_ready = 1'b1;

    pmfd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    pmfd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_status       (o_status),
        .o_voltage      (o_voltage),
        .o_current      (o_current),
        .o_power        (o_power),
        .o_energy_micro (o_energy_micro)
    );

endmodule

`default_nettype wire

// ===== verif/power_meter_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// power_meter_frame_decoder_tb
// Streams energy-meter frames into the decoder with random idling on both
// sides. A scoreboard decodes every accepted byte and checks each reading
// field by field. The run steps through several gain settings and finishes
// with back-to-back frames at full power coefficient and wrapped pulses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module power_meter_frame_decoder_tb;

    import pmfd_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   SETTLE_CYCLES  = 250;
    localparam int                   PHASE_BYTES    = 75;
    localparam int                   FILL_FRAMES    = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;

    typedef struct packed {
        t_status               status;
        logic [RES_W-1:0]      voltage;
        logic [RES_W-1:0]      current;
        logic [RES_W-1:0]      power;
        logic [ENERGY_W-1:0]   energy;
    } t_reading;

    // Decodes frames on the side and checks the readings in order.
    class meter_scoreboard;
        logic [GAIN_W-1:0]   gain_v;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_p;
        logic [BYTE_W-1:0]   frame_bytes [FRAME_LEN];
        int unsigned         fill;
        logic [BYTE_W-1:0]   running_sum;
        logic [PULSE_W-1:0]  prev_pulses;
        logic [ENERGY_W-1:0] energy_acc;
        t_reading            readings_due [$];
        int unsigned         mismatches;
        int unsigned         n_ok;
        int unsigned         n_bad_hdr;
        int unsigned         n_bad_sum;
        int unsigned         n_quot_sat;

        function new();
            gain_v      = GAIN_RESET;
            gain_i      = GAIN_RESET;
            gain_p      = GAIN_RESET;
            fill        = FRAME_LEN;
            running_sum = '0;
            prev_pulses = '0;
            energy_acc  = '0;
            mismatches  = 0;
            n_ok        = 0;
            n_bad_hdr   = 0;
            n_bad_sum   = 0;
            n_quot_sat  = 0;
        endfunction

        function void set_gain(input logic [CFG_IDX_W-1:0] idx,
                               input logic [GAIN_W-1:0] data);
            case (idx)
                CFG_VOLTAGE_GAIN: gain_v = data;
                CFG_CURRENT_GAIN: gain_i = data;
                CFG_POWER_GAIN:   gain_p = data;
                default: ;
            endcase
        endfunction

        function logic [FIELD_W-1:0] be24(input int at);
            return {frame_bytes[at], frame_bytes[at+1], frame_bytes[at+2]};
        endfunction

        // gain * coef / cycle in Q16.16, truncated, clamped to 32 bits
        function logic [RES_W-1:0] gain_ratio(input logic [GAIN_W-1:0] gain,
                                              input logic [FIELD_W-1:0] coef,
                                              input logic [FIELD_W-1:0] cycle);
            logic [63:0] num;
            logic [63:0] den;
            logic [63:0] q;
            if (cycle == '0) begin
                n_quot_sat++;
                return '1;
            end
            num = 64'(gain);
            num = num * coef;
            den = 64'(cycle);
            q   = num / den;
            if (q[63:RES_W] != '0) begin
                n_quot_sat++;
                return '1;
            end
            return q[RES_W-1:0];
        endfunction

        function void take_byte(input logic [BYTE_W-1:0] b, input logic start);
            t_reading            r;
            logic [FIELD_W-1:0]  coef_p;
            logic [PULSE_W-1:0]  pulses;
            logic [PULSE_W-1:0]  delta;
            logic [63:0]         add;
            logic [63:0]         room;
            if (start) begin
                fill        = 0;
                running_sum = '0;
            end else if (fill >= FRAME_LEN) begin
                return;
            end
            frame_bytes[fill] = b;
            if (fill >= 2 && fill <= 22)
                running_sum = running_sum + b;
            fill++;
            if (fill < FRAME_LEN)
                return;

            r = '0;
            if (frame_bytes[1] != HEADER_OK) begin
                r.status = ST_BAD_HDR;
                n_bad_hdr++;
            end else if (running_sum != frame_bytes[23]) begin
                r.status = ST_BAD_SUM;
                n_bad_sum++;
            end else begin
                r.status = ST_OK;
                n_ok++;
                coef_p = be24(14);
                if ((frame_bytes[20] & ADJ_VOLTAGE) != '0)
                    r.voltage = gain_ratio(gain_v, be24(2), be24(5));
                if ((frame_bytes[20] & ADJ_POWER) != '0 &&
                    (frame_bytes[0] & POWER_BAD_MASK) != POWER_BAD_MASK)
                    r.power = gain_ratio(gain_p, coef_p, be24(17));
                // current rides on a nonzero power reading
                if ((frame_bytes[20] & ADJ_CURRENT) != '0 && r.power != '0)
                    r.current = gain_ratio(gain_i, be24(8), be24(11));
                pulses = {frame_bytes[21], frame_bytes[22]};
                if (prev_pulses == '0)
                    prev_pulses = pulses;
                delta = pulses - prev_pulses;
                add   = 64'(delta);
                add   = add * coef_p;
                room  = {16'h0, ~energy_acc};
                if (add > room)
                    energy_acc = '1;
                else
                    energy_acc = energy_acc + add[ENERGY_W-1:0];
                prev_pulses = pulses;
            end
            r.energy = energy_acc;
            readings_due.push_back(r);
        endfunction

        task report(input string what);
            $display("[%0t] MISMATCH %s", $time, what);
            mismatches++;
        endtask

        task check_reading(input t_reading got);
            t_reading want;
            if (readings_due.size() == 0) begin
                report($sformatf("reading with none pending: status %0d energy %0h",
                                 got.status, got.energy));
                return;
            end
            want = readings_due.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.voltage !== want.voltage)
                report($sformatf("voltage got %h want %h", got.voltage, want.voltage));
            if (got.current !== want.current)
                report($sformatf("current got %h want %h", got.current, want.current));
            if (got.power !== want.power)
                report($sformatf("power got %h want %h", got.power, want.power));
            if (got.energy !== want.energy)
                report($sformatf("energy got %h want %h", got.energy, want.energy));
        endtask

        function int pending();
            return readings_due.size();
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_rx_byte     = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [1:0]            o_status;
    logic [RES_W-1:0]      o_voltage;
    logic [RES_W-1:0]      o_current;
    logic [RES_W-1:0]      o_power;
    logic [ENERGY_W-1:0]   o_energy_micro;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [GAIN_W-1:0]     i_cfg_data    = '0;

    meter_scoreboard sb;
    logic [BYTE_W-1:0] frame_buf [FRAME_LEN];
    int                send_gap_pct  = 0;
    int                stall_pct     = 0;
    int                stall_left    = 0;
    int                quiet_cycles  = 0;
    int                bytes_sent    = 0;
    int                gain_writes   = 0;
    logic [PULSE_W-1:0] pulse_walk   = 16'h0100;

    power_meter_frame_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_start  (i_frame_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_voltage      (o_voltage),
        .o_current      (o_current),
        .o_power        (o_power),
        .o_energy_micro (o_energy_micro),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the reading side in random bursts.
    always @(negedge i_clk) begin
        if (stall_left == 0 && stall_pct != 0 && $urandom_range(99) < stall_pct)
            stall_left = $urandom_range(1, 11);
        if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_reading({t_status'(o_status), o_voltage, o_current, o_power,
                              o_energy_micro});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no traffic for %0d cycles", $time, quiet_cycles);
            $display("power_meter_frame_decoder_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= start;
        // hold the word until it is taken
        do @(posedge i_clk); while (o_stall);
        sb.take_byte(b, start);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int n);
        for (int k = 0; k < n; k++) begin
            send_byte(frame_buf[k], k == 0);
            bytes_sent++;
        end
    endtask

    task automatic pack_frame(input logic [BYTE_W-1:0] lead, input logic [BYTE_W-1:0] hdr,
                              input logic [FIELD_W-1:0] cv, input logic [FIELD_W-1:0] yv,
                              input logic [FIELD_W-1:0] ci, input logic [FIELD_W-1:0] yi,
                              input logic [FIELD_W-1:0] cp, input logic [FIELD_W-1:0] yp,
                              input logic [BYTE_W-1:0] adj, input logic [PULSE_W-1:0] pulses,
                              input logic spoil_sum);
        logic [BYTE_W-1:0] sum;
        frame_buf[0] = lead;
        frame_buf[1] = hdr;
        {frame_buf[2],  frame_buf[3],  frame_buf[4]}  = cv;
        {frame_buf[5],  frame_buf[6],  frame_buf[7]}  = yv;
        {frame_buf[8],  frame_buf[9],  frame_buf[10]} = ci;
        {frame_buf[11], frame_buf[12], frame_buf[13]} = yi;
        {frame_buf[14], frame_buf[15], frame_buf[16]} = cp;
        {frame_buf[17], frame_buf[18], frame_buf[19]} = yp;
        frame_buf[20] = adj;
        {frame_buf[21], frame_buf[22]} = pulses;
        sum = '0;
        for (int k = 2; k <= 22; k++)
            sum = sum + frame_buf[k];
        frame_buf[23] = spoil_sum ? sum + BYTE_W'($urandom_range(1, 255)) : sum;
    endtask

    function automatic logic [FIELD_W-1:0] pick_field();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 24'h1;
            2:       return '1;
            3, 4:    return FIELD_W'($urandom_range(1, 255));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic random_frame();
        logic [BYTE_W-1:0]  lead;
        logic [BYTE_W-1:0]  hdr;
        logic [BYTE_W-1:0]  adj;
        logic [PULSE_W-1:0] pulses;
        lead = BYTE_W'($urandom);
        if ($urandom_range(3) == 0)
            lead = lead | POWER_BAD_MASK;
        hdr = ($urandom_range(9) == 0) ? BYTE_W'($urandom) : HEADER_OK;
        adj = BYTE_W'($urandom);
        if ($urandom_range(3) != 0)
            adj = adj | ADJ_VOLTAGE | ADJ_POWER | ADJ_CURRENT;
        case ($urandom_range(7))
            0:       pulses = '0;
            1:       pulses = PULSE_W'($urandom);
            default: begin
                pulse_walk = pulse_walk + PULSE_W'($urandom_range(0, 400));
                pulses     = pulse_walk;
            end
        endcase
        pack_frame(lead, hdr, pick_field(), pick_field(), pick_field(), pick_field(),
                   pick_field(), pick_field(), adj, pulses, $urandom_range(9) == 0);
    endtask

    // Called at a falling edge; the caller drops i_cfg_valid after the batch.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_gain(idx, data);
        gain_writes++;
        @(negedge i_clk);
    endtask

    task automatic write_gains(input logic [GAIN_W-1:0] gv, input logic [GAIN_W-1:0] gi,
                               input logic [GAIN_W-1:0] gp);
        write_cfg(CFG_VOLTAGE_GAIN, gv);
        write_cfg(CFG_CURRENT_GAIN, gi);
        write_cfg(CFG_POWER_GAIN, gp);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait out every pending reading plus the decode tail.
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    int gap_plan   [6] = '{20, 0, 40, 10, 30, 5};
    int stall_plan [6] = '{20, 0, 40, 10, 0, 25};

    initial begin
        int                 phase_bytes;
        logic [PULSE_W-1:0] fill_pulses;
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: stray word while idle, a frame cut short by a new start,
        // then one frame hitting both quotient saturations at reset gains.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(HEADER_OK, 1'b0);
        bytes_sent += 2;
        pack_frame(8'h00, HEADER_OK, 24'hFFFFFF, 24'h000001, 24'h000001, 24'h000000,
                   24'hFFFFFF, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b0);
        send_frame(FRAME_LEN);

        for (int ph = 0; ph < 6; ph++) begin
            i_valid <= 1'b0;
            drain();
            case (ph)
                0: write_gains('1, '1, '1);
                1: write_gains('0, '0, '0);
                3: begin
                    write_cfg(CFG_SPARE, $urandom);
                    write_gains(GAIN_RESET, GAIN_RESET, GAIN_RESET);
                end
                4: write_gains($urandom_range(1, 1 << 17), $urandom_range(1, 1 << 17),
                               $urandom_range(1, 1 << 17));
                default: write_gains($urandom, $urandom, $urandom);
            endcase
            send_gap_pct = gap_plan[ph];
            stall_pct    = stall_plan[ph];
            phase_bytes  = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_bytes) begin
                case ($urandom_range(19))
                    0: send_byte(BYTE_W'($urandom), 1'b0);
                    1: begin
                        random_frame();
                        send_frame($urandom_range(1, FRAME_LEN - 1));
                    end
                    default: begin
                        random_frame();
                        send_frame(FRAME_LEN);
                    end
                endcase
            end
            // close the phase on a whole frame so the decoder ends idle
            random_frame();
            send_frame(FRAME_LEN);
        end

        // Last part, no idling: full power coefficient and a pulse count
        // that steps back by one each frame, i.e. a wrapped delta of 65535.
        i_valid <= 1'b0;
        drain();
        write_gains($urandom, $urandom, $urandom);
        send_gap_pct = 0;
        stall_pct    = 0;
        fill_pulses  = 16'hFFFF;
        for (int f = 0; f < FILL_FRAMES; f++) begin
            pack_frame(BYTE_W'($urandom), HEADER_OK, pick_field(), pick_field(), pick_field(),
                       pick_field(), 24'hFFFFFF, pick_field(), BYTE_W'($urandom),
                       fill_pulses, 1'b0);
            send_frame(FRAME_LEN);
            fill_pulses = fill_pulses - 1'b1;
        end
        i_valid <= 1'b0;
        drain();

        $display("run: %0d frame bytes, %0d gain writes; frames ok %0d, bad header %0d,",
                 bytes_sent, gain_writes, sb.n_ok, sb.n_bad_hdr);
        $display("     bad checksum %0d; %0d saturated quotients; energy at full scale: %0d",
                 sb.n_bad_sum, sb.n_quot_sat, sb.energy_acc == '1);
        if (sb.mismatches == 0) begin
            $display("power_meter_frame_decoder_tb: clean");
        end else begin
            $display("power_meter_frame_decoder_tb: errors");
        end
        $finish;
    end

endmodule
